// File: hdl/lant_pkg.sv
// ----------------------------------------------------------------------------
// Langton ant step package
// Shared constants, register indexes and the heading type of the ant core.
// ----------------------------------------------------------------------------
package lant_pkg;

   // Default grid size and move counter width.
   localparam int DEF_MAX_ROWS   = 64;
   localparam int DEF_MAX_COLS   = 64;
   localparam int DEF_COUNT_BITS = 16;

   // Positions are kept in six bits whatever the grid size.
   localparam int POS_W    = 6;
   localparam int POS_SPAN = 64;

   // Widths of the external fields and registers.
   localparam int SPAN_W  = 7;
   localparam int LIMIT_W = 16;
   localparam int MOVES_W = 16;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   // Register reset values.
   localparam logic [SPAN_W-1:0]  RST_ROWS  = 7'd64;
   localparam logic [SPAN_W-1:0]  RST_COLS  = 7'd64;
   localparam logic [LIMIT_W-1:0] RST_LIMIT = 16'd0;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_ROWS_IN_USE = 3'd0,
      REG_COLS_IN_USE = 3'd1,
      REG_START_ROW   = 3'd2,
      REG_START_COL   = 3'd3,
      REG_MOVE_LIMIT  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      HEAD_NORTH = 2'd0,
      HEAD_EAST  = 2'd1,
      HEAD_SOUTH = 2'd2,
      HEAD_WEST  = 2'd3
   } heading_type;

endpackage

// File: hdl/langton_ant_step_core.sv
// ----------------------------------------------------------------------------
// Langton ant step core
// Moves Langton's ant one cell per request on a bounded grid of one-bit cells
// held in a synchronous memory, and reports the ant after every request.
// ----------------------------------------------------------------------------
// Usage:
// Each request transfer carries req_advance. With advance set, and the move
// limit not yet reached, the ant reads its cell, turns, repaints the cell,
// bounces off an edge if it faces one, and steps. Every request produces
// exactly one response transfer with the ant's position, heading, the color
// written to the cell it left, the move count and the finished flag.
// Timing: the grid read is issued at the edge that accepts the request, and
// the response is registered in the output register once that register is
// free; rsp_valid then rises.
// Requests do not overlap: the grid memory is read at the accepting edge and
// written at the edge that registers the response, and the next read address
// is the position this move produces, so a new request waits for that write.
// Reset: the configuration registers, the ant state and the valid flags
// return to their reset values, and the memory is then swept to white, one
// cell a cycle. req_ready stays low during the sweep; register writes on
// the csr_ port are taken at all times.
// Stall: a response that is not taken waits in the output register. One
// more request can still be accepted; it waits in the read stage until the
// output register is free, and req_ready stays low meanwhile.
// Registers must be written only while no request is in flight (not enforced).
// ----------------------------------------------------------------------------
module langton_ant_step_core #(
   parameter int MAX_ROWS   = lant_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = lant_pkg::DEF_MAX_COLS,
   parameter int COUNT_BITS = lant_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_advance,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lant_pkg::POS_W-1:0]    rsp_ant_row,
   output logic [lant_pkg::POS_W-1:0]    rsp_ant_col,
   output logic [1:0]                    rsp_heading,
   output logic                          rsp_left_cell_black,
   output logic [lant_pkg::MOVES_W-1:0]  rsp_moves_done,
   output logic                          rsp_finished,
   // Register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lant_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lant_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lant_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import lant_pkg::*;

   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(CELLS);
   // The used span never exceeds what a six-bit position can cover.
   localparam int ROW_HI = (MAX_ROWS < POS_SPAN) ? MAX_ROWS : POS_SPAN;
   localparam int COL_HI = (MAX_COLS < POS_SPAN) ? MAX_COLS : POS_SPAN;
   localparam logic [SPAN_W-1:0] ROW_HI_V = SPAN_W'(ROW_HI);
   localparam logic [SPAN_W-1:0] COL_HI_V = SPAN_W'(COL_HI);
   localparam logic [SPAN_W-1:0] SPAN_MIN = SPAN_W'(2);
   // The count is compared against the limit at the wider of the two widths.
   localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   logic [SPAN_W-1:0]  rows_cfg_ff, rows_cfg_in;
   logic [SPAN_W-1:0]  cols_cfg_ff, cols_cfg_in;
   logic [POS_W-1:0]   start_row_ff, start_row_in;
   logic [POS_W-1:0]   start_col_ff, start_col_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_wr;
   reg_index_type      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      start_row_in = start_row_ff;
      start_col_in = start_col_ff;
      limit_in     = limit_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_ROWS_IN_USE: rows_cfg_in  = csr_pwdata[SPAN_W-1:0];
            REG_COLS_IN_USE: cols_cfg_in  = csr_pwdata[SPAN_W-1:0];
            REG_START_ROW:   start_row_in = csr_pwdata[POS_W-1:0];
            REG_START_COL:   start_col_in = csr_pwdata[POS_W-1:0];
            REG_MOVE_LIMIT:  limit_in     = csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ROWS_IN_USE: csr_prdata = CSR_DW'(rows_cfg_ff);
         REG_COLS_IN_USE: csr_prdata = CSR_DW'(cols_cfg_ff);
         REG_START_ROW:   csr_prdata = CSR_DW'(start_row_ff);
         REG_START_COL:   csr_prdata = CSR_DW'(start_col_ff);
         REG_MOVE_LIMIT:  csr_prdata = CSR_DW'(limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= RST_ROWS;
         cols_cfg_ff  <= RST_COLS;
         start_row_ff <= '0;
         start_col_ff <= '0;
         limit_ff     <= RST_LIMIT;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         start_row_ff <= start_row_in;
         start_col_ff <= start_col_in;
         limit_ff     <= limit_in;
      end
   end

   // Last used row and column. Sizes out of range are clamped to two at the
   // low end and to the smaller of the grid and the position span above.
   logic [SPAN_W-1:0] row_span, col_span;
   logic [POS_W-1:0]  last_row, last_col;

   always_comb begin
      row_span = (rows_cfg_ff < SPAN_MIN) ? SPAN_MIN :
                 (rows_cfg_ff > ROW_HI_V) ? ROW_HI_V : rows_cfg_ff;
      col_span = (cols_cfg_ff < SPAN_MIN) ? SPAN_MIN :
                 (cols_cfg_ff > COL_HI_V) ? COL_HI_V : cols_cfg_ff;
      last_row = POS_W'(row_span - 1'b1);
      last_col = POS_W'(col_span - 1'b1);
   end

   // ---------------------------------------------------------------------
   // Ant state
   // ---------------------------------------------------------------------
   logic [POS_W-1:0]      pos_row_ff, pos_row_in;
   logic [POS_W-1:0]      pos_col_ff, pos_col_in;
   heading_type           dir_ff, dir_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // ---------------------------------------------------------------------
   // Read stage: a request is accepted and its cell is read. The stage
   // register keeps the request until the step stage can finish it.
   // ---------------------------------------------------------------------
   logic              req_xfer;
   logic              st_valid_ff, st_valid_in;
   logic              st_adv_ff;
   logic              st_ok_ff;
   logic [ADDR_W-1:0] st_addr_ff;
   logic              cur_ok;
   logic [ADDR_W-1:0] cur_addr;
   logic              clear_busy;
   logic              rd_bit;
   logic              st_done;
   logic              rsp_valid_ff, rsp_valid_in;

   // A cell outside the memory reads as white and is never written.
   assign cur_ok   = (int'(pos_row_ff) < MAX_ROWS) && (int'(pos_col_ff) < MAX_COLS);
   assign cur_addr = ADDR_W'(ADDR_W'(pos_row_ff) * ADDR_W'(MAX_COLS))
                     + ADDR_W'(pos_col_ff);

   // The stage holds at most one request, so the write of one move always
   // lands before the read of the next one: no forwarding is needed.
   assign req_ready = ~clear_busy & ~st_valid_ff;
   assign req_xfer  = req_valid & req_ready;
   assign st_done   = st_valid_ff & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      st_valid_in = st_valid_ff;
      if (req_xfer) begin
         st_valid_in = 1'b1;
      end else if (st_done) begin
         st_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         st_adv_ff  <= req_advance;
         st_ok_ff   <= cur_ok;
         st_addr_ff <= cur_addr;
      end
   end

   // ---------------------------------------------------------------------
   // Step stage: turn, repaint, bounce off an edge, step.
   // ---------------------------------------------------------------------
   logic             cell_black;
   logic             first_move;
   logic             limit_hit;
   logic             do_move;
   logic             painted;
   heading_type      turned;
   heading_type      bounced;
   logic [POS_W-1:0] next_row;
   logic [POS_W-1:0] next_col;
   logic             cell_we;

   always_comb begin
      cell_black = st_ok_ff & rd_bit;
      first_move = (count_ff == '0);
      limit_hit  = (CMP_W'(count_ff) >= CMP_W'(limit_ff));
      do_move    = st_adv_ff & ~limit_hit;
      // The very first move paints without turning.
      painted    = first_move | ~cell_black;
      if (first_move) begin
         turned = dir_ff;
      end else if (cell_black) begin
         turned = heading_type'(dir_ff - 2'd1);
      end else begin
         turned = heading_type'(dir_ff + 2'd1);
      end
      // A position at or past the last row or column counts as on that edge.
      if (pos_col_ff == '0 && turned == HEAD_WEST) begin
         bounced = HEAD_EAST;
      end else if (pos_row_ff == '0 && turned == HEAD_NORTH) begin
         bounced = HEAD_SOUTH;
      end else if (pos_col_ff >= last_col && turned == HEAD_EAST) begin
         bounced = HEAD_WEST;
      end else if (pos_row_ff >= last_row && turned == HEAD_SOUTH) begin
         bounced = HEAD_NORTH;
      end else begin
         bounced = turned;
      end
      next_row = pos_row_ff;
      next_col = pos_col_ff;
      case (bounced)
         HEAD_NORTH: if (pos_row_ff != '0) next_row = pos_row_ff - 1'b1;
         HEAD_EAST:  next_col = pos_col_ff + 1'b1;
         HEAD_SOUTH: next_row = pos_row_ff + 1'b1;
         HEAD_WEST:  if (pos_col_ff != '0) next_col = pos_col_ff - 1'b1;
         default: ;
      endcase
      cell_we = st_done & do_move & st_ok_ff;
   end

   // A start write relocates the ant at once; heading and count stay.
   always_comb begin
      pos_row_in = pos_row_ff;
      pos_col_in = pos_col_ff;
      dir_in     = dir_ff;
      count_in   = count_ff;
      if (st_done && do_move) begin
         pos_row_in = next_row;
         pos_col_in = next_col;
         dir_in     = bounced;
         count_in   = count_ff + 1'b1;
      end
      if (csr_wr && csr_idx == REG_START_ROW) begin
         pos_row_in = start_row_in;
      end
      if (csr_wr && csr_idx == REG_START_COL) begin
         pos_col_in = start_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_row_ff <= '0;
         pos_col_ff <= '0;
         dir_ff     <= HEAD_NORTH;
         count_ff   <= '0;
      end else begin
         pos_row_ff <= pos_row_in;
         pos_col_ff <= pos_col_in;
         dir_ff     <= dir_in;
         count_ff   <= count_in;
      end
   end

   lant_cell_ram #(
      .CELLS (CELLS)
   ) u_cell_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_xfer),
      .rd_addr    (cur_addr),
      .rd_data    (rd_bit),
      .wr_en      (cell_we),
      .wr_addr    (st_addr_ff),
      .wr_data    (painted),
      .clear_busy (clear_busy)
   );

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [POS_W-1:0]   rsp_row_ff;
   logic [POS_W-1:0]   rsp_col_ff;
   heading_type        rsp_head_ff;
   logic               rsp_paint_ff;
   logic [MOVES_W-1:0] rsp_moves_ff;
   logic               rsp_fin_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (st_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_done) begin
         rsp_row_ff   <= do_move ? next_row : pos_row_ff;
         rsp_col_ff   <= do_move ? next_col : pos_col_ff;
         rsp_head_ff  <= do_move ? bounced : dir_ff;
         rsp_paint_ff <= do_move & painted;
         rsp_moves_ff <= do_move ? MOVES_W'(count_ff + 1'b1) : MOVES_W'(count_ff);
         rsp_fin_ff   <= ~do_move & limit_hit;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ant_row         = rsp_row_ff;
   assign rsp_ant_col         = rsp_col_ff;
   assign rsp_heading         = rsp_head_ff;
   assign rsp_left_cell_black = rsp_paint_ff;
   assign rsp_moves_done      = rsp_moves_ff;
   assign rsp_finished        = rsp_fin_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The ant's own writes never collide with the clearing sweep.
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      cell_we |-> !clear_busy)
      else $error("grid written by a move during the clearing sweep");

   // Every move lands on a different cell.
   a_move_changes_cell: assert property (@(posedge clock) disable iff (reset)
      (st_done && do_move && !csr_wr) |=>
         (pos_row_ff != $past(pos_row_ff) || pos_col_ff != $past(pos_col_ff)))
      else $error("ant did not leave its cell on a move");

   // Each move advances the count by exactly one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (st_done && do_move) |=> count_ff == $past(count_ff + 1'b1))
      else $error("move count did not advance by one");

   // A finished tick reports no paint.
   a_finished_no_paint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_finished && rsp_left_cell_black))
      else $error("finished response reports a painted cell");

endmodule

// File: hdl/lant_cell_ram.sv
// ----------------------------------------------------------------------------
// Langton ant cell memory
// One-bit grid memory with a registered read port, one write port and a
// clearing sweep after reset that paints every cell white.
// ----------------------------------------------------------------------------
module lant_cell_ram #(
   parameter int CELLS = lant_pkg::DEF_MAX_ROWS * lant_pkg::DEF_MAX_COLS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(CELLS)-1:0] rd_addr,
   output logic                     rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(CELLS)-1:0] wr_addr,
   input  logic                     wr_data,
   output logic                     clear_busy
);
   import lant_pkg::*;

   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   logic              cell_mem [CELLS];
   logic              rd_data_ff;
   logic              clearing_ff;
   logic              clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic              mem_wd;

   // The sweep owns the write port until the last cell is white.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
      mem_we = clearing_ff | wr_en;
      mem_wa = clearing_ff ? clr_addr_ff : wr_addr;
      mem_wd = clearing_ff ? 1'b0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

endmodule
